// ===== sv/segisect_pkg.sv =====
`timescale 1ns / 1ps
// Package for the segment intersection core: coordinate width, derived
// datapath widths and the query and result transaction types. No dependencies.
package segisect_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;           // endpoint differences
  localparam int PROD_W      = 2 * DIFF_W;                // difference products
  localparam int CROSS_W     = PROD_W + 1;                // cross products
  localparam int LO_W        = COORD_WIDTH + 2;           // low slice of a cross product
  localparam int HI_W        = CROSS_W - LO_W;            // high slice of a cross product
  localparam int PL_W        = LO_W + 1 + DIFF_W;         // low partial product
  localparam int PH_W        = HI_W + DIFF_W;             // high partial product
  localparam int NUM_W       = 3 * COORD_WIDTH + 5;       // point numerator
  localparam int QUO_W       = COORD_WIDTH + 1;           // quotient magnitude bits
  localparam int DIV_LAT     = QUO_W + 2;                 // divider latency

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } query_t;

  typedef struct packed {
    logic   hit;
    logic   parallel;
    coord_t point_x;
    coord_t point_y;
    logic   saturated;
  } result_t;

endpackage

// ===== sv/segisect_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider with truncation toward zero and saturation to
// the coordinate width. Depends on segisect_pkg.
module segisect_div
  import segisect_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [NUM_W-1:0]   num,
  input  logic signed [CROSS_W-1:0] den,
  output coord_t                    value,
  output logic                      sat
);

  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [CROSS_W-1:0] rem  [0:QUO_W];
  logic [QUO_W-1:0]   quo  [0:QUO_W];
  logic [QUO_W-1:0]   low  [0:QUO_W];
  logic [CROSS_W-1:0] ud   [0:QUO_W];
  logic               neg  [0:QUO_W];
  logic               ovf  [0:QUO_W];

  logic [NUM_W-1:0]   un_abs;
  logic [CROSS_W-1:0] ud_abs;

  assign un_abs = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign ud_abs = den[CROSS_W-1] ? (~den + 1'b1) : den;

  // First stage: magnitudes, sign of the quotient and the early overflow test.
  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= num[NUM_W-1] ^ den[CROSS_W-1];
      ud[0]  <= ud_abs;
      ovf[0] <= (un_abs >> QUO_W) >= NUM_W'(ud_abs);
      rem[0] <= un_abs[QUO_W+CROSS_W-1:QUO_W];
      low[0] <= un_abs[QUO_W-1:0];
      quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [CROSS_W:0] trial;
    logic             ge;
    logic [CROSS_W:0] diff;

    assign trial = {rem[k], low[k][QUO_W-1-k]};
    assign ge    = trial >= {1'b0, ud[k]};
    assign diff  = trial - {1'b0, ud[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[CROSS_W-1:0] : trial[CROSS_W-1:0];
        quo[k+1] <= {quo[k][QUO_W-2:0], ge};
        low[k+1] <= low[k];
        ud[k+1]  <= ud[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  logic [QUO_W-1:0] qm;
  logic             pos_big;
  logic             neg_big;

  // A positive magnitude clips from the largest value plus one upward; a
  // negative one only beyond the magnitude of the smallest value.
  assign qm      = quo[QUO_W];
  assign pos_big = qm[QUO_W-1] | qm[QUO_W-2];
  assign neg_big = qm[QUO_W-1] | (qm[QUO_W-2] & (|qm[QUO_W-3:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[QUO_W]) begin
        sat   <= 1'b1;
        value <= neg[QUO_W] ? CMIN : CMAX;
      end else if (!neg[QUO_W]) begin
        sat   <= pos_big;
        value <= pos_big ? CMAX : qm[COORD_WIDTH-1:0];
      end else begin
        sat   <= neg_big;
        value <= neg_big ? CMIN : (~qm[COORD_WIDTH-1:0] + 1'b1);
      end
    end
  end

endmodule

// ===== sv/segment_intersection_core.sv =====
`timescale 1ns / 1ps
// Top level of the segment intersection core: a deep pipeline of difference,
// cross product and partial product stages feeding two dividers. Uses segisect_pkg.
//
// Usage: each query transaction carries segment A and segment B as start and
// end points in signed Q12.4. Each query yields exactly one result transaction
// holding hit, parallel, the line crossing point (Q12.4, saturated) and a
// saturated flag. Both channels use valid and stall; a transaction moves at a
// rising edge where valid is high and stall is low.
// The pipeline holds six arithmetic stages (differences, products, cross
// products, split multiplies, partial sums, numerator sums) followed by the
// divider, which resolves one quotient bit per stage plus an entry and a clip
// stage. Throughput is one query per cycle while no held result stalls the
// pipeline. The whole pipeline advances on one enable; when the result is held
// by result_stall, every stage freezes and query_stall is raised, so nothing
// is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits; payload registers are not reset.
module segment_intersection_core
  import segisect_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_stall,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int PIPE_LEN = 6 + DIV_LAT;

  logic                en;
  logic [PIPE_LEN-1:0] vld;

  // The pipeline moves unless a finished result is waiting on the receiver.
  assign en           = !(result_valid && result_stall);
  assign query_stall  = !en;
  assign result_valid = vld[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], query_valid};
    end
  end

  // Stage 1: direction vectors r and s, offset w and the start point of A.
  logic signed [DIFF_W-1:0] rx1, ry1, sx1, sy1, wx1, wy1, px1, py1;

  always_ff @(posedge clk) begin
    if (en) begin
      rx1 <= DIFF_W'(query.a_end_x) - DIFF_W'(query.a_start_x);
      ry1 <= DIFF_W'(query.a_end_y) - DIFF_W'(query.a_start_y);
      sx1 <= DIFF_W'(query.b_end_x) - DIFF_W'(query.b_start_x);
      sy1 <= DIFF_W'(query.b_end_y) - DIFF_W'(query.b_start_y);
      wx1 <= DIFF_W'(query.b_start_x) - DIFF_W'(query.a_start_x);
      wy1 <= DIFF_W'(query.b_start_y) - DIFF_W'(query.a_start_y);
      px1 <= DIFF_W'(query.a_start_x);
      py1 <= DIFF_W'(query.a_start_y);
    end
  end

  // Stage 2: the six products behind d = r x s, tn = w x s and un = w x r.
  logic signed [PROD_W-1:0] m_rxsy, m_rysx, m_wxsy, m_wysx, m_wxry, m_wyrx;
  logic signed [DIFF_W-1:0] px2, py2, rx2, ry2;

  always_ff @(posedge clk) begin
    if (en) begin
      m_rxsy <= rx1 * sy1;
      m_rysx <= ry1 * sx1;
      m_wxsy <= wx1 * sy1;
      m_wysx <= wy1 * sx1;
      m_wxry <= wx1 * ry1;
      m_wyrx <= wy1 * rx1;
      px2    <= px1;
      py2    <= py1;
      rx2    <= rx1;
      ry2    <= ry1;
    end
  end

  // Stage 3: cross products.
  logic signed [CROSS_W-1:0] d3, tn3, un3;
  logic signed [DIFF_W-1:0]  px3, py3, rx3, ry3;

  always_ff @(posedge clk) begin
    if (en) begin
      d3  <= CROSS_W'(m_rxsy) - CROSS_W'(m_rysx);
      tn3 <= CROSS_W'(m_wxsy) - CROSS_W'(m_wysx);
      un3 <= CROSS_W'(m_wxry) - CROSS_W'(m_wyrx);
      px3 <= px2;
      py3 <= py2;
      rx3 <= rx2;
      ry3 <= ry2;
    end
  end

  // A parameter lies in [0,1] when its numerator sits between 0 and d,
  // with the bounds swapped when d is negative.
  function automatic logic in_unit(input logic signed [CROSS_W-1:0] num,
                                   input logic signed [CROSS_W-1:0] den);
    if (den < 0) begin
      return (num >= den) && (num <= 0);
    end
    return (num >= 0) && (num <= den);
  endfunction

  // Stage 4: hit and parallel flags, and the numerators px*d + tn*rx and
  // py*d + tn*ry as split multiplies on the low and high slices of d and tn.
  logic                      hit4, par4;
  logic signed [CROSS_W-1:0] d4;
  logic signed [PL_W-1:0]    pxdl, pydl, tnrxl, tnryl;
  logic signed [PH_W-1:0]    pxdh, pydh, tnrxh, tnryh;
  logic signed [HI_W-1:0]    d_hi, tn_hi;

  assign d_hi  = d3[CROSS_W-1:LO_W];
  assign tn_hi = tn3[CROSS_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      par4  <= (d3 == 0);
      hit4  <= (d3 != 0) && in_unit(tn3, d3) && in_unit(un3, d3);
      d4    <= d3;
      pxdl  <= $signed({1'b0, d3[LO_W-1:0]}) * px3;
      pydl  <= $signed({1'b0, d3[LO_W-1:0]}) * py3;
      tnrxl <= $signed({1'b0, tn3[LO_W-1:0]}) * rx3;
      tnryl <= $signed({1'b0, tn3[LO_W-1:0]}) * ry3;
      pxdh  <= d_hi * px3;
      pydh  <= d_hi * py3;
      tnrxh <= tn_hi * rx3;
      tnryh <= tn_hi * ry3;
    end
  end

  // Stage 5: recombine the slices.
  logic                      hit5, par5;
  logic signed [CROSS_W-1:0] d5;
  logic signed [NUM_W-1:0]   pxd5, pyd5, tnrx5, tnry5;

  always_ff @(posedge clk) begin
    if (en) begin
      hit5  <= hit4;
      par5  <= par4;
      d5    <= d4;
      pxd5  <= (NUM_W'(pxdh) <<< LO_W) + NUM_W'(pxdl);
      pyd5  <= (NUM_W'(pydh) <<< LO_W) + NUM_W'(pydl);
      tnrx5 <= (NUM_W'(tnrxh) <<< LO_W) + NUM_W'(tnrxl);
      tnry5 <= (NUM_W'(tnryh) <<< LO_W) + NUM_W'(tnryl);
    end
  end

  // Stage 6: crossing point numerators over the common denominator d.
  logic                      hit6, par6;
  logic signed [CROSS_W-1:0] d6;
  logic signed [NUM_W-1:0]   nx6, ny6;

  always_ff @(posedge clk) begin
    if (en) begin
      hit6 <= hit5;
      par6 <= par5;
      d6   <= d5;
      nx6  <= pxd5 + tnrx5;
      ny6  <= pyd5 + tnry5;
    end
  end

  // Division stages for both coordinates; the flags ride alongside.
  coord_t vx, vy;
  logic   satx, saty;

  segisect_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num   (nx6),
    .den   (d6),
    .value (vx),
    .sat   (satx)
  );

  segisect_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num   (ny6),
    .den   (d6),
    .value (vy),
    .sat   (saty)
  );

  logic [DIV_LAT-1:0] hit_sr, par_sr;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_sr <= {hit_sr[DIV_LAT-2:0], hit6};
      par_sr <= {par_sr[DIV_LAT-2:0], par6};
    end
  end

  // A zero denominator forces the point and the saturated flag to zero.
  always_comb begin
    result.hit       = hit_sr[DIV_LAT-1];
    result.parallel  = par_sr[DIV_LAT-1];
    result.point_x   = par_sr[DIV_LAT-1] ? '0 : vx;
    result.point_y   = par_sr[DIV_LAT-1] ? '0 : vy;
    result.saturated = !par_sr[DIV_LAT-1] && (satx || saty);
  end

`ifndef SYNTHESIS
  localparam coord_t PT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t PT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (query_valid && !query_stall) |=> vld[0])
    else $error("accepted query did not enter the pipeline");

  a_hit_not_parallel: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.hit && result.parallel))
    else $error("hit reported for parallel segments");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.saturated) |->
      (result.point_x == PT_MAX || result.point_x == PT_MIN ||
       result.point_y == PT_MAX || result.point_y == PT_MIN))
    else $error("saturated flag without a clipped coordinate");
`endif

endmodule
